### rtl/core/fspa_pkg.sv
// ============================================================================
// fspa_pkg - shared types and constants of the fixed slot pool allocator
// Sizes, status and command codes, register indexes and the datapath
// structs that pass between the sequencer and the divider.
// ============================================================================
`default_nettype none

package fspa_pkg;

    // Pool geometry
    localparam int unsigned MAX_SLOTS    = 1024;
    localparam int unsigned ADDR_BITS    = 48;
    localparam int unsigned ALIGN_BYTES  = 16;
    localparam int unsigned ALIGN_SHIFT  = 4;
    localparam int unsigned SLOT_IDX_W   = 10;
    localparam int unsigned COUNT_W      = 11;
    localparam int unsigned REQ_W        = 17;
    localparam int unsigned UNITS_W      = REQ_W + 1 - ALIGN_SHIFT;
    localparam int unsigned QUO_W        = ADDR_BITS - ALIGN_SHIFT;
    localparam int unsigned DIV_CNT_W    = 6;
    localparam int unsigned STAT_W       = 32;
    localparam int unsigned STATUS_W     = 3;

    // Free-mark memory: one row holds the marks of 32 slots
    localparam int unsigned MARK_ROW_W     = 32;
    localparam int unsigned MARK_BIT_W     = 5;
    localparam int unsigned MARK_ROWS      = MAX_SLOTS / MARK_ROW_W;
    localparam int unsigned MARK_ROW_IDX_W = SLOT_IDX_W - MARK_BIT_W;

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = ADDR_BITS;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_ADDRESS = 2'd0,
        CFG_PIECE_SIZE   = 2'd1,
        CFG_SLOT_COUNT   = 2'd2
    } cfg_index_t;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_EMPTY       = 3'd1,
        ST_OUTSIDE     = 3'd2,
        ST_MISALIGNED  = 3'd3,
        ST_DOUBLE_FREE = 3'd4
    } status_t;

    // Divider control and status
    typedef struct packed {
        logic               start;
        logic [QUO_W-1:0]   dividend;
        logic [UNITS_W-1:0] divisor;
    } div_ctrl_t;

    typedef struct packed {
        logic               done;
        logic [QUO_W-1:0]   quotient;
        logic [UNITS_W-1:0] remainder;
    } div_stat_t;

    // Clamp the slot count register to the supported range
    function automatic logic [COUNT_W-1:0] eff_count(input logic [COUNT_W-1:0] cnt);
        logic [COUNT_W-1:0] res;
        res = cnt;
        if (cnt < COUNT_W'(2))
        begin
            res = COUNT_W'(2);
        end
        else if (cnt > COUNT_W'(MAX_SLOTS))
        begin
            res = COUNT_W'(MAX_SLOTS);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### rtl/core/fspa_if.sv
// ============================================================================
// fspa_if - request and response channels of the pool allocator
// Valid/ready channels; a transfer happens when both are high at a clock edge.
// ============================================================================
`default_nettype none

interface fspa_req_if;
    import fspa_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 command;
    logic [ADDR_BITS-1:0] address;

    modport source (output valid, output command, output address, input ready);
    modport sink   (input valid, input command, input address, output ready);
endinterface

interface fspa_rsp_if;
    import fspa_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [STATUS_W-1:0]   status;
    logic [ADDR_BITS-1:0]  slot_address;
    logic [SLOT_IDX_W-1:0] slot_index;
    logic [COUNT_W-1:0]    free_slots;
    logic [STAT_W-1:0]     alloc_requests;
    logic [STAT_W-1:0]     alloc_failures;
    logic [STAT_W-1:0]     frees_done;
    logic [STAT_W-1:0]     double_frees;

    modport source (
        output valid, output status, output slot_address, output slot_index,
        output free_slots, output alloc_requests, output alloc_failures,
        output frees_done, output double_frees, input ready
    );
    modport sink (
        input valid, input status, input slot_address, input slot_index,
        input free_slots, input alloc_requests, input alloc_failures,
        input frees_done, input double_frees, output ready
    );
endinterface

`default_nettype wire

### rtl/core/fspa_ram.sv
// ============================================================================
// fspa_ram - simple dual-port memory
// One write port and one read port, read data registered.
// ============================================================================
`default_nettype none

module fspa_ram #(
    parameter int unsigned DATA_W = 8,
    parameter int unsigned DEPTH  = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [DATA_W-1:0]        wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/core/fspa_div.sv
// ============================================================================
// fspa_div - iterative restoring divider
// Divides the aligned byte offset by the slot size in 16-byte units,
// one quotient bit per cycle.
// ============================================================================
`default_nettype none

module fspa_div (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire fspa_pkg::div_ctrl_t ctrl,
    output fspa_pkg::div_stat_t      stat
);
    import fspa_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [QUO_W-1:0]     quo_reg;
    logic [UNITS_W-1:0]   rem_reg;
    logic [UNITS_W-1:0]   dvs_reg;

    logic [UNITS_W:0]     trial;
    logic                 fits;
    logic [UNITS_W:0]     diff;

    // Shift in the next dividend bit and try the subtraction
    assign trial = {rem_reg, quo_reg[QUO_W-1]};
    assign fits  = (trial >= {1'b0, dvs_reg});
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(QUO_W);
                quo_reg  <= ctrl.dividend;
                rem_reg  <= '0;
                dvs_reg  <= ctrl.divisor;
            end
            else if (busy_reg)
            begin
                rem_reg <= fits ? diff[UNITS_W-1:0] : trial[UNITS_W-1:0];
                quo_reg <= {quo_reg[QUO_W-2:0], fits};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.done      = done_reg;
    assign stat.quotient  = quo_reg;
    assign stat.remainder = rem_reg;

endmodule

`default_nettype wire

### rtl/core/fixed_slot_pool_allocator.sv
// ============================================================================
// fixed_slot_pool_allocator - pool of equal slots with a LIFO free stack
// Allocate pops a free index and answers its byte address; free checks the
// address with the divider, catches double frees and pushes the index.
// ============================================================================
//
//  channel | dir | handshake    | payload
//  --------+-----+--------------+------------------------------------------
//  req     | in  | valid/ready  | command, address
//  rsp     | out | valid/ready  | status, slot_address, slot_index,
//          |     |              | free_slots, four statistics counters
//  cfg     | in  | cfg_we       | cfg_index, cfg_data
//
//  Allocate runs through stack read, mark read-modify-write with the index
//  multiply, base add and result load. A free at or above the base waits
//  for the divider's 44 one-bit steps, then checks range, alignment and mark.
//  After reset and after each slot_count write the free marks are set by a
//  pass over the 32 mark memory rows, one row a cycle; req.ready stays low.
//  One request is in work at a time; a finished result waits in the output
//  register while the next request is taken.
//
`default_nettype none

module fixed_slot_pool_allocator (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    fspa_req_if.sink                           req,
    fspa_rsp_if.source                         rsp,
    input  wire logic                          cfg_we,
    input  wire logic [fspa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [fspa_pkg::CFG_DATA_W-1:0] cfg_data
);
    import fspa_pkg::*;

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_A_POP,
        S_A_MARK,
        S_F_DIV,
        S_F_MARK,
        S_DONE
    } state_t;

    state_t                    state_reg;
    logic [MARK_ROW_IDX_W-1:0] sweep_row_reg;

    // Configuration
    logic [ADDR_BITS-1:0]  base_reg;
    logic [REQ_W-1:0]      piece_reg;
    logic [COUNT_W-1:0]    count_reg;

    // Pool state
    logic [COUNT_W-1:0]    fill_reg;
    logic [COUNT_W-1:0]    low_reg;
    logic [STAT_W-1:0]     alloc_req_reg;
    logic [STAT_W-1:0]     alloc_fail_reg;
    logic [STAT_W-1:0]     free_done_reg;
    logic [STAT_W-1:0]     dbl_free_reg;

    // Work registers
    logic [SLOT_IDX_W-1:0]         pos_reg;
    logic                          fresh_reg;
    logic [SLOT_IDX_W-1:0]         idx_reg;
    logic [SLOT_IDX_W+UNITS_W-1:0] prod_reg;
    logic                          nib_nz_reg;
    status_t                       res_status_reg;
    logic [ADDR_BITS-1:0]          res_addr_reg;
    logic [SLOT_IDX_W-1:0]         res_index_reg;

    // Output register
    logic                  out_valid_reg;
    status_t               out_status_reg;
    logic [ADDR_BITS-1:0]  out_addr_reg;
    logic [SLOT_IDX_W-1:0] out_index_reg;
    logic [COUNT_W-1:0]    out_free_reg;
    logic [STAT_W-1:0]     out_areq_reg;
    logic [STAT_W-1:0]     out_afail_reg;
    logic [STAT_W-1:0]     out_fdone_reg;
    logic [STAT_W-1:0]     out_dfree_reg;

    // Derived values
    logic [COUNT_W-1:0]    n_eff;
    logic [REQ_W-1:0]      piece_eff;
    logic [REQ_W:0]        req_round;
    logic [UNITS_W-1:0]    units;
    logic [ADDR_BITS-1:0]  offset;
    logic [COUNT_W-1:0]    fill_m1;
    logic                  accept;
    logic                  out_load;
    logic [SLOT_IDX_W-1:0] pop_idx;
    logic [SLOT_IDX_W-1:0] stk_rd_data;
    logic [MARK_ROW_W-1:0] mark_rd_data;
    logic [MARK_ROW_W-1:0] mark_bit;
    logic                  mark_set;
    logic                  push_ok;

    // Memory ports
    logic                      stk_rd_en;
    logic                      stk_wr_en;
    logic                      mark_rd_en;
    logic [MARK_ROW_IDX_W-1:0] mark_rd_row;
    logic                      mark_wr_en;
    logic [MARK_ROW_IDX_W-1:0] mark_wr_row;
    logic [MARK_ROW_W-1:0]     mark_wr_data;

    div_ctrl_t div_ctrl;
    div_stat_t div_stat;

    // Slot size in 16-byte units; a zero request counts as one byte
    assign n_eff     = eff_count(count_reg);
    assign piece_eff = (piece_reg == '0) ? REQ_W'(1) : piece_reg;
    assign req_round = {1'b0, piece_eff} + (REQ_W+1)'(ALIGN_BYTES - 1);
    assign units     = req_round[REQ_W:ALIGN_SHIFT];

    assign offset  = req.address - base_reg;
    assign fill_m1 = fill_reg - 1'b1;
    assign accept  = req.valid && req.ready;
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || rsp.ready);

    // Entries below the low-water mark were never pushed since the refill
    assign pop_idx = fresh_reg ? pos_reg : stk_rd_data;

    assign mark_bit = MARK_ROW_W'(1) << idx_reg[MARK_BIT_W-1:0];
    assign mark_set = |(mark_rd_data & mark_bit);
    assign push_ok  = (fill_reg < COUNT_W'(MAX_SLOTS));

    assign req.ready = (state_reg == S_IDLE);

    // Divider start
    always_comb
    begin
        div_ctrl.start    = accept && (req.command == CMD_FREE) &&
                            (req.address >= base_reg);
        div_ctrl.dividend = offset[ADDR_BITS-1:ALIGN_SHIFT];
        div_ctrl.divisor  = units;
    end

    // Memory port steering
    always_comb
    begin
        stk_rd_en    = accept && (req.command == CMD_ALLOC) && (fill_reg != '0);
        stk_wr_en    = (state_reg == S_F_MARK) && !mark_set && push_ok;
        mark_rd_en   = 1'b0;
        mark_rd_row  = pop_idx[SLOT_IDX_W-1:MARK_BIT_W];
        mark_wr_en   = 1'b0;
        mark_wr_row  = idx_reg[SLOT_IDX_W-1:MARK_BIT_W];
        mark_wr_data = mark_rd_data & ~mark_bit;
        unique case (state_reg)
            S_SWEEP:
            begin
                mark_wr_en   = 1'b1;
                mark_wr_row  = sweep_row_reg;
                mark_wr_data = '1;
            end
            S_A_POP:
            begin
                mark_rd_en = 1'b1;
            end
            S_A_MARK:
            begin
                mark_wr_en = 1'b1;
            end
            S_F_DIV:
            begin
                mark_rd_en  = div_stat.done;
                mark_rd_row = div_stat.quotient[SLOT_IDX_W-1:MARK_BIT_W];
            end
            S_F_MARK:
            begin
                mark_wr_en   = !mark_set;
                mark_wr_data = mark_rd_data | mark_bit;
            end
            default:
            begin
            end
        endcase
    end

    fspa_ram #(
        .DATA_W (SLOT_IDX_W),
        .DEPTH  (MAX_SLOTS)
    ) u_stack (
        .clk     (clk),
        .wr_en   (stk_wr_en),
        .wr_addr (fill_reg[SLOT_IDX_W-1:0]),
        .wr_data (idx_reg),
        .rd_en   (stk_rd_en),
        .rd_addr (fill_m1[SLOT_IDX_W-1:0]),
        .rd_data (stk_rd_data)
    );

    fspa_ram #(
        .DATA_W (MARK_ROW_W),
        .DEPTH  (MARK_ROWS)
    ) u_marks (
        .clk     (clk),
        .wr_en   (mark_wr_en),
        .wr_addr (mark_wr_row),
        .wr_data (mark_wr_data),
        .rd_en   (mark_rd_en),
        .rd_addr (mark_rd_row),
        .rd_data (mark_rd_data)
    );

    fspa_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (div_ctrl),
        .stat  (div_stat)
    );

    // Sequencer, pool state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_SWEEP;
            sweep_row_reg  <= '0;
            base_reg       <= '0;
            piece_reg      <= REQ_W'(ALIGN_BYTES);
            count_reg      <= COUNT_W'(MAX_SLOTS);
            fill_reg       <= COUNT_W'(MAX_SLOTS);
            low_reg        <= COUNT_W'(MAX_SLOTS);
            alloc_req_reg  <= '0;
            alloc_fail_reg <= '0;
            free_done_reg  <= '0;
            dbl_free_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            // Drop the result once taken unless a new one loads below
            if (rsp.ready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_SWEEP:
                begin
                    sweep_row_reg <= sweep_row_reg + 1'b1;
                    if (sweep_row_reg == MARK_ROW_IDX_W'(MARK_ROWS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        res_status_reg <= ST_OK;
                        res_addr_reg   <= '0;
                        res_index_reg  <= '0;
                        if (req.command == CMD_ALLOC)
                        begin
                            alloc_req_reg <= alloc_req_reg + 1'b1;
                            if (fill_reg == '0)
                            begin
                                alloc_fail_reg <= alloc_fail_reg + 1'b1;
                                res_status_reg <= ST_EMPTY;
                                state_reg      <= S_DONE;
                            end
                            else
                            begin
                                fill_reg  <= fill_m1;
                                pos_reg   <= fill_m1[SLOT_IDX_W-1:0];
                                fresh_reg <= (fill_m1 < low_reg);
                                if (fill_m1 < low_reg)
                                begin
                                    low_reg <= fill_m1;
                                end
                                state_reg <= S_A_POP;
                            end
                        end
                        else if (req.address < base_reg)
                        begin
                            res_status_reg <= ST_OUTSIDE;
                            state_reg      <= S_DONE;
                        end
                        else
                        begin
                            nib_nz_reg <= |offset[ALIGN_SHIFT-1:0];
                            state_reg  <= S_F_DIV;
                        end
                    end
                end
                S_A_POP:
                begin
                    idx_reg   <= pop_idx;
                    prod_reg  <= pop_idx * units;
                    state_reg <= S_A_MARK;
                end
                S_A_MARK:
                begin
                    res_addr_reg  <= base_reg + (ADDR_BITS'(prod_reg) << ALIGN_SHIFT);
                    res_index_reg <= idx_reg;
                    state_reg     <= S_DONE;
                end
                S_F_DIV:
                begin
                    if (div_stat.done)
                    begin
                        idx_reg <= div_stat.quotient[SLOT_IDX_W-1:0];
                        if (div_stat.quotient >= QUO_W'(n_eff))
                        begin
                            res_status_reg <= ST_OUTSIDE;
                            state_reg      <= S_DONE;
                        end
                        else if (nib_nz_reg || (div_stat.remainder != '0))
                        begin
                            res_status_reg <= ST_MISALIGNED;
                            state_reg      <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_F_MARK;
                        end
                    end
                end
                S_F_MARK:
                begin
                    res_index_reg <= idx_reg;
                    if (mark_set)
                    begin
                        dbl_free_reg   <= dbl_free_reg + 1'b1;
                        res_status_reg <= ST_DOUBLE_FREE;
                    end
                    else
                    begin
                        if (push_ok)
                        begin
                            fill_reg <= fill_reg + 1'b1;
                        end
                        free_done_reg <= free_done_reg + 1'b1;
                    end
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_load)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= res_status_reg;
                        out_addr_reg   <= res_addr_reg;
                        out_index_reg  <= res_index_reg;
                        out_free_reg   <= fill_reg;
                        out_areq_reg   <= alloc_req_reg;
                        out_afail_reg  <= alloc_fail_reg;
                        out_fdone_reg  <= free_done_reg;
                        out_dfree_reg  <= dbl_free_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            // Register writes; a slot count write refills the pool
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_BASE_ADDRESS:
                    begin
                        base_reg <= cfg_data[ADDR_BITS-1:0];
                    end
                    CFG_PIECE_SIZE:
                    begin
                        piece_reg <= cfg_data[REQ_W-1:0];
                    end
                    CFG_SLOT_COUNT:
                    begin
                        count_reg     <= cfg_data[COUNT_W-1:0];
                        fill_reg      <= eff_count(cfg_data[COUNT_W-1:0]);
                        low_reg       <= eff_count(cfg_data[COUNT_W-1:0]);
                        sweep_row_reg <= '0;
                        state_reg     <= S_SWEEP;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.slot_address   = out_addr_reg;
    assign rsp.slot_index     = out_index_reg;
    assign rsp.free_slots     = out_free_reg;
    assign rsp.alloc_requests = out_areq_reg;
    assign rsp.alloc_failures = out_afail_reg;
    assign rsp.frees_done     = out_fdone_reg;
    assign rsp.double_frees   = out_dfree_reg;

`ifndef SYNTH
    // The stack never holds more than the pool can have
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= COUNT_W'(MAX_SLOTS))
        else $error("free stack fill above pool size");

    // The low-water mark never rises above the current fill
    a_low_water: assert property (@(posedge clk) disable iff (!rst_n)
        low_reg <= fill_reg)
        else $error("stack low-water mark above fill");

    // A divider result only arrives while a free request waits for it
    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == S_F_DIV))
        else $error("divider finished outside of a free request");

    // An accepted request leaves the idle state
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != S_IDLE))
        else $error("request accepted without starting work");
`endif

endmodule

`default_nettype wire

### bench/fixed_slot_pool_allocator_test.sv
`timescale 1ns / 1ps
// ============================================================================
// fixed_slot_pool_allocator_test - self-checking bench of the slot allocator
// Drives allocate and free requests over the valid/ready channels under
// random idling and one long response stall. A behavioral copy of the pool
// (free stack, free marks, counters) predicts every response, which is then
// compared field by field. The pool geometry is rewritten between phases.
// ============================================================================

module fixed_slot_pool_allocator_test;
    import fspa_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;
    localparam int RANDOM_ITEMS = 1350;
    localparam logic [ADDR_BITS-1:0] ADDR_ALL_ONES = '1;

    typedef struct {
        status_t                status;
        logic [ADDR_BITS-1:0]   slot_address;
        logic [SLOT_IDX_W-1:0]  slot_index;
        logic [COUNT_W-1:0]     free_slots;
        logic [STAT_W-1:0]      alloc_requests;
        logic [STAT_W-1:0]      alloc_failures;
        logic [STAT_W-1:0]      frees_done;
        logic [STAT_W-1:0]      double_frees;
    } pool_response_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    fspa_req_if req_ch ();
    fspa_rsp_if rsp_ch ();

    fixed_slot_pool_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Pool copy used for prediction
    logic [ADDR_BITS-1:0]  pool_base;
    logic [REQ_W-1:0]      pool_piece;
    logic [COUNT_W-1:0]    pool_count;
    logic [SLOT_IDX_W-1:0] free_stack [MAX_SLOTS];
    bit                    slot_is_free [MAX_SLOTS];
    int unsigned           stack_depth;
    logic [STAT_W-1:0]     alloc_total;
    logic [STAT_W-1:0]     alloc_refused;
    logic [STAT_W-1:0]     free_total;
    logic [STAT_W-1:0]     double_free_total;

    pool_response_t pending_responses [$];
    int             mismatch_count = 0;
    bit             idle_on = 1'b1;
    int             rsp_hold_cycles = 0;

    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Pool prediction
    // ------------------------------------------------------------------------
    function automatic int unsigned active_slots();
        int unsigned n;
        n = pool_count;
        if (n < 2)
        begin
            n = 2;
        end
        if (n > MAX_SLOTS)
        begin
            n = MAX_SLOTS;
        end
        return n;
    endfunction

    // Round the piece size up to whole alignment units; zero acts as one byte
    function automatic logic [63:0] slot_size();
        logic [63:0] piece;
        piece = (pool_piece == '0) ? 64'd1 : 64'(pool_piece);
        return ((piece + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
    endfunction

    function automatic logic [ADDR_BITS-1:0] slot_addr(input int unsigned slot);
        logic [63:0] sum;
        sum = 64'(pool_base) + 64'(slot) * slot_size();
        return sum[ADDR_BITS-1:0];
    endfunction

    function automatic void refill_pool();
        for (int i = 0; i < MAX_SLOTS; i++)
        begin
            free_stack[i]   = SLOT_IDX_W'(i);
            slot_is_free[i] = 1'b1;
        end
        stack_depth = active_slots();
    endfunction

    function automatic void reset_pool_model();
        pool_base         = '0;
        pool_piece        = REQ_W'(16);
        pool_count        = COUNT_W'(MAX_SLOTS);
        alloc_total       = '0;
        alloc_refused     = '0;
        free_total        = '0;
        double_free_total = '0;
        refill_pool();
    endfunction

    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] value);
        unique case (idx)
            CFG_BASE_ADDRESS: pool_base = value[ADDR_BITS-1:0];
            CFG_PIECE_SIZE:   pool_piece = value[REQ_W-1:0];
            CFG_SLOT_COUNT:
            begin
                pool_count = value[COUNT_W-1:0];
                refill_pool();
            end
            default: ;
        endcase
    endfunction

    // Work out the response to one accepted request and advance the pool
    function automatic pool_response_t pool_respond(input cmd_t cmd,
                                                    input logic [ADDR_BITS-1:0] addr);
        pool_response_t r;
        logic [ADDR_BITS-1:0] offset;
        logic [63:0] quot;
        logic [63:0] rem;
        int unsigned slot;
        r.status       = ST_OK;
        r.slot_address = '0;
        r.slot_index   = '0;
        if (cmd == CMD_ALLOC)
        begin
            alloc_total++;
            if (stack_depth == 0)
            begin
                alloc_refused++;
                r.status = ST_EMPTY;
            end
            else
            begin
                stack_depth--;
                slot = free_stack[stack_depth];
                slot_is_free[slot] = 1'b0;
                r.slot_address = slot_addr(slot);
                r.slot_index   = SLOT_IDX_W'(slot);
            end
        end
        else if (addr < pool_base)
        begin
            r.status = ST_OUTSIDE;
        end
        else
        begin
            offset = addr - pool_base;
            quot   = 64'(offset) / slot_size();
            rem    = 64'(offset) % slot_size();
            if (quot >= 64'(active_slots()))
            begin
                r.status = ST_OUTSIDE;
            end
            else if (rem != 0)
            begin
                r.status = ST_MISALIGNED;
            end
            else
            begin
                slot = 32'(quot);
                r.slot_index = SLOT_IDX_W'(slot);
                if (slot_is_free[slot])
                begin
                    double_free_total++;
                    r.status = ST_DOUBLE_FREE;
                end
                else
                begin
                    slot_is_free[slot] = 1'b1;
                    if (stack_depth < MAX_SLOTS)
                    begin
                        free_stack[stack_depth] = SLOT_IDX_W'(slot);
                        stack_depth++;
                    end
                    free_total++;
                end
            end
        end
        r.free_slots     = COUNT_W'(stack_depth);
        r.alloc_requests = alloc_total;
        r.alloc_failures = alloc_refused;
        r.frees_done     = free_total;
        r.double_frees   = double_free_total;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [ADDR_BITS-1:0] rand48();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[ADDR_BITS-1:0];
    endfunction

    // Pick a random slot below the active count whose mark matches
    function automatic bit pick_slot(input bit want_free, output int unsigned slot);
        int unsigned candidates [$];
        for (int unsigned i = 0; i < active_slots(); i++)
        begin
            if (slot_is_free[i] == want_free)
            begin
                candidates.insert(candidates.size(), i);
            end
        end
        slot = 0;
        if (candidates.size() == 0)
        begin
            return 1'b0;
        end
        slot = candidates[$urandom_range(0, candidates.size() - 1)];
        return 1'b1;
    endfunction

    // Mostly allocates and frees of live slots, with a share of bad frees
    function automatic void next_random_request(output cmd_t cmd,
                                                output logic [ADDR_BITS-1:0] addr);
        int unsigned roll;
        int unsigned slot;
        roll = $urandom_range(0, 99);
        cmd  = CMD_FREE;
        addr = rand48();
        if (roll < 45)
        begin
            cmd = CMD_ALLOC;
        end
        else if (roll < 75)
        begin
            if (pick_slot(1'b0, slot))
                addr = slot_addr(slot);
            else
                cmd = CMD_ALLOC;
        end
        else if (roll < 82)
        begin
            if (pick_slot(1'b1, slot))
                addr = slot_addr(slot);
            else
                cmd = CMD_ALLOC;
        end
        else if (roll < 88)
        begin
            slot = $urandom_range(0, active_slots() - 1);
            addr = slot_addr(slot) + ADDR_BITS'($urandom_range(1, 32'(slot_size() - 1)));
        end
        else if (roll < 93)
        begin
            addr = slot_addr(active_slots() + $urandom_range(0, 3));
        end
        else if (roll < 96)
        begin
            if (pool_base != '0)
                addr = rand48() % pool_base;
        end
        else
        begin
            cmd = cmd_t'($urandom_range(0, 1));
        end
    endfunction

    // Offer one request; valid stays high afterwards so a zero gap runs back to back
    task automatic send_request(input cmd_t cmd, input logic [ADDR_BITS-1:0] addr);
        int gap;
        gap = idle_on ? $urandom_range(0, 6) : 0;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.command <= cmd;
        req_ch.address <= addr;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
        begin
            @(posedge clk);
        end
        pending_responses.insert(pending_responses.size(), pool_respond(cmd, addr));
    endtask

    // Drop valid and wait for every outstanding response
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_responses.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        apply_register(idx, value);
    endtask

    // New geometry for a random phase, extremes included
    task automatic randomize_geometry();
        bit wrote;
        logic [CFG_DATA_W-1:0] value;
        wrote = 1'b0;
        if ($urandom_range(0, 4) < 3)
        begin
            case ($urandom_range(0, 4))
                0:       value = '0;
                1:       value = ADDR_ALL_ONES - ADDR_BITS'($urandom_range(0, 4096));
                default: value = rand48();
            endcase
            write_register(CFG_BASE_ADDRESS, value);
            wrote = 1'b1;
        end
        if ($urandom_range(0, 4) < 3)
        begin
            case ($urandom_range(0, 5))
                0:       value = '0;
                1:       value = CFG_DATA_W'(131071);
                2:       value = CFG_DATA_W'(65536);
                3:       value = CFG_DATA_W'($urandom_range(1, 64));
                4:       value = CFG_DATA_W'($urandom_range(1, 2000));
                default: value = CFG_DATA_W'($urandom_range(0, 131071));
            endcase
            write_register(CFG_PIECE_SIZE, value);
            wrote = 1'b1;
        end
        if ($urandom_range(0, 9) == 0)
        begin
            write_register(CFG_UNUSED_INDEX, rand48());
        end
        if (!wrote || $urandom_range(0, 4) < 4)
        begin
            case ($urandom_range(0, 9))
                6:
                begin
                    case ($urandom_range(0, 3))
                        0:       value = '0;
                        1:       value = CFG_DATA_W'(1);
                        2:       value = CFG_DATA_W'(2047);
                        default: value = CFG_DATA_W'(MAX_SLOTS);
                    endcase
                end
                7:       value = CFG_DATA_W'($urandom_range(0, 2047));
                8:       value = CFG_DATA_W'($urandom_range(13, 64));
                9:       value = CFG_DATA_W'(MAX_SLOTS);
                default: value = CFG_DATA_W'($urandom_range(2, 12));
            endcase
            write_register(CFG_SLOT_COUNT, value);
        end
    endtask

    // ------------------------------------------------------------------------
    // Response checking
    // ------------------------------------------------------------------------
    function automatic void check_field(input string field, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", field, want, got);
            mismatch_count++;
        end
    endfunction

    initial
    begin : response_checker
        pool_response_t want;
        int stall;
        stall = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            // compare an accepted response with the oldest prediction
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            begin
                if (pending_responses.size() == 0)
                begin
                    $error("response with no request outstanding");
                    mismatch_count++;
                end
                else
                begin
                    want = pending_responses.pop_front();
                    check_field("status", want.status, rsp_ch.status);
                    check_field("slot_address", want.slot_address, rsp_ch.slot_address);
                    check_field("slot_index", want.slot_index, rsp_ch.slot_index);
                    check_field("free_slots", want.free_slots, rsp_ch.free_slots);
                    check_field("alloc_requests", want.alloc_requests,
                                rsp_ch.alloc_requests);
                    check_field("alloc_failures", want.alloc_failures,
                                rsp_ch.alloc_failures);
                    check_field("frees_done", want.frees_done, rsp_ch.frees_done);
                    check_field("double_frees", want.double_frees, rsp_ch.double_frees);
                end
                stall = idle_on ? $urandom_range(0, 6) : 0;
            end
            // hold off on request of a test, else idle after each response
            if (rsp_hold_cycles > 0)
            begin
                rsp_ch.ready <= 1'b0;
                rsp_hold_cycles--;
            end
            else if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset geometry: 1024 slots of 16 bytes at address zero
    task automatic test_reset_defaults();
        send_request(CMD_ALLOC, ADDR_ALL_ONES);
        send_request(CMD_FREE, slot_addr(MAX_SLOTS - 1));
        send_request(CMD_FREE, slot_addr(MAX_SLOTS - 1));
        send_request(CMD_FREE, slot_addr(MAX_SLOTS - 1) + 8);
        send_request(CMD_FREE, slot_addr(MAX_SLOTS));
        send_request(CMD_FREE, ADDR_ALL_ONES);
        send_request(CMD_FREE, '0);
    endtask

    // Slot count below range and zero piece size: two 16-byte slots
    task automatic test_small_pool();
        wait_idle();
        write_register(CFG_BASE_ADDRESS, CFG_DATA_W'(48'h1000));
        write_register(CFG_PIECE_SIZE, '0);
        write_register(CFG_SLOT_COUNT, '0);
        send_request(CMD_ALLOC, '0);
        send_request(CMD_ALLOC, ADDR_ALL_ONES);
        send_request(CMD_ALLOC, '0);
        send_request(CMD_FREE, pool_base - 1);
        send_request(CMD_FREE, slot_addr(2));
        send_request(CMD_FREE, slot_addr(0) + 8);
        send_request(CMD_FREE, slot_addr(0));
        send_request(CMD_FREE, slot_addr(0));
        send_request(CMD_ALLOC, '0);
    endtask

    // Largest piece and count above range near the top of the address space
    task automatic test_wrapping_pool();
        wait_idle();
        write_register(CFG_BASE_ADDRESS, CFG_DATA_W'(48'hFFFF_FFFF_FF00));
        write_register(CFG_PIECE_SIZE, CFG_DATA_W'(131071));
        write_register(CFG_SLOT_COUNT, CFG_DATA_W'(2047));
        write_register(CFG_UNUSED_INDEX, ADDR_ALL_ONES);
        send_request(CMD_ALLOC, '0);
        send_request(CMD_FREE, slot_addr(MAX_SLOTS - 1));
        send_request(CMD_FREE, pool_base);
        send_request(CMD_FREE, slot_addr(1));
        send_request(CMD_FREE, ADDR_ALL_ONES);
    endtask

    // Stall the response side long enough for the request side to back up
    task automatic test_output_backpressure();
        int unsigned slot;
        wait_idle();
        write_register(CFG_BASE_ADDRESS, rand48());
        write_register(CFG_PIECE_SIZE, CFG_DATA_W'(17));
        write_register(CFG_SLOT_COUNT, CFG_DATA_W'(8));
        idle_on = 1'b0;
        rsp_hold_cycles = 300;
        repeat (12) send_request(CMD_ALLOC, rand48());
        repeat (6)
        begin
            if (pick_slot(1'b0, slot))
                send_request(CMD_FREE, slot_addr(slot));
        end
        idle_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        int sent;
        int phase_len;
        cmd_t cmd;
        logic [ADDR_BITS-1:0] addr;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            wait_idle();
            randomize_geometry();
            idle_on = ($urandom_range(0, 3) != 0);
            phase_len = $urandom_range(60, 140);
            repeat (phase_len)
            begin
                next_random_request(cmd, addr);
                send_request(cmd, addr);
            end
            sent += phase_len;
        end
        idle_on = 1'b1;
    endtask

    initial
    begin : test_sequence
        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_index      <= CFG_BASE_ADDRESS;
        cfg_data       <= '0;
        req_ch.valid   <= 1'b0;
        req_ch.command <= CMD_ALLOC;
        req_ch.address <= '0;
        reset_pool_model();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_small_pool();
        test_wrapping_pool();
        test_output_backpressure();
        test_random_traffic();

        // drain, then leave room for any stray response
        wait_idle();
        repeat (60) @(posedge clk);
        if (mismatch_count == 0 && pending_responses.size() == 0)
        begin
            $display("fixed_slot_pool_allocator_test OK");
        end
        else
        begin
            $display("fixed_slot_pool_allocator_test NOT OK");
        end
        $finish;
    end

    initial
    begin : run_limit
        #2_000_000;
        $display("fixed_slot_pool_allocator_test NOT OK");
        $finish;
    end

endmodule
